>>> sv/usbcds_pkg.sv
package usbcds_pkg;

   localparam int BYTE_WIDTH = 8;
   localparam int MPS_WIDTH  = 11;
   localparam int PEND_DEPTH = 7;

   localparam logic [BYTE_WIDTH-1:0] TYPE_INTERFACE   = 8'd4;
   localparam logic [BYTE_WIDTH-1:0] TYPE_ENDPOINT    = 8'd5;
   localparam logic [BYTE_WIDTH-1:0] IFACE_MIN_LEN    = 8'd9;
   localparam logic [BYTE_WIDTH-1:0] EP_MIN_LEN       = 8'd7;
   localparam logic [BYTE_WIDTH-1:0] MIN_DESC_LEN     = 8'd2;
   localparam logic [BYTE_WIDTH-1:0] XFER_MASK        = 8'h03;
   localparam logic [BYTE_WIDTH-1:0] XFER_INTERRUPT   = 8'h03;
   localparam logic [BYTE_WIDTH-1:0] DIR_IN           = 8'h80;
   localparam logic [MPS_WIDTH-1:0]  MPS_DEFAULT      = 11'd8;
   localparam logic [BYTE_WIDTH-1:0] INTERVAL_DEFAULT = 8'd10;

   typedef logic [BYTE_WIDTH-1:0] byte_type;

   typedef struct packed {
      logic                 iface_found;
      byte_type             iface_class;
      byte_type             iface_subclass;
      byte_type             iface_protocol;
      byte_type             iface_number;
      logic                 ep_found;
      byte_type             ep_address;
      logic [MPS_WIDTH-1:0] ep_max_packet;
      byte_type             ep_interval;
      logic                 malformed;
   } result_type;

endpackage

>>> sv/usbcds_if.sv
interface usbcds_req_if;
   import usbcds_pkg::*;

   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface usbcds_rsp_if;
   import usbcds_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 iface_found;
   byte_type             iface_class;
   byte_type             iface_subclass;
   byte_type             iface_protocol;
   byte_type             iface_number;
   logic                 ep_found;
   byte_type             ep_address;
   logic [MPS_WIDTH-1:0] ep_max_packet;
   byte_type             ep_interval;
   logic                 malformed;

   modport source (
      output valid, output iface_found, output iface_class, output iface_subclass,
      output iface_protocol, output iface_number, output ep_found, output ep_address,
      output ep_max_packet, output ep_interval, output malformed, input ready
   );
   modport sink (
      input valid, input iface_found, input iface_class, input iface_subclass,
      input iface_protocol, input iface_number, input ep_found, input ep_address,
      input ep_max_packet, input ep_interval, input malformed, output ready
   );
endinterface

>>> sv/usb_config_descriptor_scanner.sv
// USB configuration descriptor scanner.
//
// Feed the descriptor set on the req channel, one byte per request, with
// last_byte high on the final byte. The block walks the length-prefixed
// descriptors and, for every request marked last, returns one response on the
// rsp channel: the first complete interface descriptor, the first complete
// interrupt IN endpoint descriptor (defaults when none), and a malformed flag
// set when a length byte below 2 stopped the walk. Non-last bytes give no
// response.
//
// Throughput: one byte per cycle while req_ready is high; the parser updates on every byte taken.
// Output: each response is registered in the result register, or in the skid register if that waits.
// Stall: a two-entry output buffer (result register plus skid register) keeps
// req_ready high while one response waits; ready drops only when both are
// full, and rises again the cycle after rsp drains one.
// Reset: synchronous, active high; clears the parser, both records and the
// output buffer. Once a last byte is taken the parser is back in its reset
// state, so the next set may follow at once.
module usb_config_descriptor_scanner (
   input logic clock,
   input logic reset,
   usbcds_req_if.sink   req,
   usbcds_rsp_if.source rsp
);
   import usbcds_pkg::*;

   // Parser state
   byte_type   desc_length_ff, desc_length_in;
   byte_type   desc_position_ff, desc_position_in;
   byte_type   desc_kind_ff, desc_kind_in;
   logic       parse_stopped_ff, parse_stopped_in;
   byte_type   pend_ff [PEND_DEPTH];
   byte_type   pend_in [PEND_DEPTH];

   // Found records
   logic                 if_found_ff, if_found_in;
   byte_type             if_class_ff, if_class_in;
   byte_type             if_sub_ff, if_sub_in;
   byte_type             if_proto_ff, if_proto_in;
   byte_type             if_num_ff, if_num_in;
   logic                 ep_have_ff, ep_have_in;
   byte_type             ep_addr_ff, ep_addr_in;
   logic [MPS_WIDTH-1:0] ep_mps_ff, ep_mps_in;
   byte_type             ep_int_ff, ep_int_in;

   // Output buffer
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   result_type result;

   logic       accept;
   logic       emit;
   logic       out_pop;

   // Values after this byte, before the end-of-set clear
   byte_type   length_upd, position_upd, kind_upd;
   logic       stopped_upd, finish;
   logic       if_take, ep_take;
   logic [MPS_WIDTH-1:0] mps_raw;

   assign req.ready = !skid_valid_ff;
   assign accept    = req.valid && req.ready;
   assign emit      = accept && req.last_byte;
   assign out_pop   = out_valid_ff && rsp.ready;

   always_comb begin
      length_upd   = desc_length_ff;
      position_upd = desc_position_ff;
      kind_upd     = desc_kind_ff;
      stopped_upd  = parse_stopped_ff;
      finish       = 1'b0;
      for (int i = 0; i < PEND_DEPTH; i++) begin
         pend_in[i] = pend_ff[i];
      end

      if (accept && !parse_stopped_ff) begin
         if (desc_position_ff == '0) begin
            // Length byte: start a descriptor or stop on a short length
            length_upd = req.data_byte;
            if (req.data_byte < MIN_DESC_LEN) begin
               if (!req.last_byte) begin
                  stopped_upd = 1'b1;
               end
            end else begin
               position_upd = 8'd1;
            end
         end else begin
            if (desc_position_ff == 8'd1) begin
               kind_upd = req.data_byte;
            end
            for (int i = 0; i < PEND_DEPTH; i++) begin
               if (desc_position_ff == BYTE_WIDTH'(i + 2)) begin
                  pend_in[i] = req.data_byte;
               end
            end
            if (desc_position_ff == desc_length_ff - 8'd1) begin
               finish       = 1'b1;
               position_upd = '0;
            end else begin
               position_upd = desc_position_ff + 8'd1;
            end
         end
      end

      // Judge a descriptor whose final byte just arrived
      if_take = finish && (kind_upd == TYPE_INTERFACE) && (desc_length_ff >= IFACE_MIN_LEN)
                && !if_found_ff;
      ep_take = finish && !((kind_upd == TYPE_INTERFACE) && (desc_length_ff >= IFACE_MIN_LEN))
                && (kind_upd == TYPE_ENDPOINT) && (desc_length_ff >= EP_MIN_LEN)
                && ((pend_in[1] & XFER_MASK) == XFER_INTERRUPT)
                && ((pend_in[0] & DIR_IN) != '0) && !ep_have_ff;
      mps_raw = {pend_in[3][MPS_WIDTH-BYTE_WIDTH-1:0], pend_in[2]};

      if_found_in = if_found_ff || if_take;
      if_num_in   = if_take ? pend_in[0] : if_num_ff;
      if_class_in = if_take ? pend_in[3] : if_class_ff;
      if_sub_in   = if_take ? pend_in[4] : if_sub_ff;
      if_proto_in = if_take ? pend_in[5] : if_proto_ff;
      ep_have_in  = ep_have_ff || ep_take;
      ep_addr_in  = ep_take ? pend_in[0] : ep_addr_ff;
      ep_int_in   = ep_take ? pend_in[4] : ep_int_ff;
      ep_mps_in   = ep_mps_ff;
      if (ep_take) begin
         ep_mps_in = (mps_raw == '0) ? MPS_DEFAULT : mps_raw;
      end

      result.iface_found    = if_found_in;
      result.iface_class    = if_class_in;
      result.iface_subclass = if_sub_in;
      result.iface_protocol = if_proto_in;
      result.iface_number   = if_num_in;
      result.ep_found       = ep_have_in;
      result.ep_address     = ep_addr_in;
      result.ep_max_packet  = ep_mps_in;
      result.ep_interval    = ep_int_in;
      result.malformed      = stopped_upd;

      desc_length_in   = length_upd;
      desc_position_in = position_upd;
      desc_kind_in     = kind_upd;
      parse_stopped_in = stopped_upd;

      // Drop everything back to reset values once the set ends
      if (emit) begin
         desc_length_in   = '0;
         desc_position_in = '0;
         desc_kind_in     = '0;
         parse_stopped_in = 1'b0;
         if_found_in      = 1'b0;
         if_class_in      = '0;
         if_sub_in        = '0;
         if_proto_in      = '0;
         if_num_in        = '0;
         ep_have_in       = 1'b0;
         ep_addr_in       = '0;
         ep_mps_in        = MPS_DEFAULT;
         ep_int_in        = INTERVAL_DEFAULT;
      end
   end

   // Two-entry output buffer: result register in front, skid behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || out_pop) begin
         out_valid_in = emit;
         out_in       = result;
      end else if (emit) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_length_ff   <= '0;
         desc_position_ff <= '0;
         desc_kind_ff     <= '0;
         parse_stopped_ff <= 1'b0;
         if_found_ff      <= 1'b0;
         if_class_ff      <= '0;
         if_sub_ff        <= '0;
         if_proto_ff      <= '0;
         if_num_ff        <= '0;
         ep_have_ff       <= 1'b0;
         ep_addr_ff       <= '0;
         ep_mps_ff        <= MPS_DEFAULT;
         ep_int_ff        <= INTERVAL_DEFAULT;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         desc_length_ff   <= desc_length_in;
         desc_position_ff <= desc_position_in;
         desc_kind_ff     <= desc_kind_in;
         parse_stopped_ff <= parse_stopped_in;
         if_found_ff      <= if_found_in;
         if_class_ff      <= if_class_in;
         if_sub_ff        <= if_sub_in;
         if_proto_ff      <= if_proto_in;
         if_num_ff        <= if_num_in;
         ep_have_ff       <= ep_have_in;
         ep_addr_ff       <= ep_addr_in;
         ep_mps_ff        <= ep_mps_in;
         ep_int_ff        <= ep_int_in;
         out_valid_ff     <= out_valid_in;
         skid_valid_ff    <= skid_valid_in;
      end
   end

   // Payload holds need no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < PEND_DEPTH; i++) begin
         pend_ff[i] <= pend_in[i];
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.iface_found    = out_ff.iface_found;
   assign rsp.iface_class    = out_ff.iface_class;
   assign rsp.iface_subclass = out_ff.iface_subclass;
   assign rsp.iface_protocol = out_ff.iface_protocol;
   assign rsp.iface_number   = out_ff.iface_number;
   assign rsp.ep_found       = out_ff.ep_found;
   assign rsp.ep_address     = out_ff.ep_address;
   assign rsp.ep_max_packet  = out_ff.ep_max_packet;
   assign rsp.ep_interval    = out_ff.ep_interval;
   assign rsp.malformed      = out_ff.malformed;

   // The skid entry is only ever filled behind a waiting result
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid while result register is empty");

   // A stopped walk never sits inside a descriptor
   assert property (@(posedge clock) disable iff (reset)
      parse_stopped_ff |-> (desc_position_ff == '0))
      else $error("parser stopped mid-descriptor");

   // A found endpoint never reports a zero packet size
   assert property (@(posedge clock) disable iff (reset) ep_have_ff |-> (ep_mps_ff != '0))
      else $error("endpoint record holds zero max packet size");

   // The last byte leaves the parser and records cleared
   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.last_byte) |=>
         (desc_position_ff == '0) && !parse_stopped_ff && !if_found_ff && !ep_have_ff)
      else $error("parser not cleared after last byte");

   // A last byte taken while the result register is free shows up next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.last_byte && (!out_valid_ff || rsp.ready)) |=> out_valid_ff)
      else $error("response missing after last byte");

endmodule
